### src/gcw_pkg.sv
`timescale 1ns / 1ps

package gcw_pkg;

  // default grid size
  localparam int GRID_COLS_DEF = 64;
  localparam int GRID_ROWS_DEF = 64;

  // width that holds any grid dimension up to 256 for range checks
  localparam int COORD_CMP_W = 9;

  // port field widths
  localparam int POS_W  = 6;
  localparam int KIND_W = 3;

  // occupancy codes
  localparam logic [1:0] CELL_FREE      = 2'd0;
  localparam logic [1:0] CELL_BLOCKED   = 2'd1;
  localparam logic [1:0] CELL_VISITED   = 2'd2;
  localparam logic [1:0] CELL_REVISITED = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_OBSTACLE     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STARTED      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADVANCED     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BACKTRACKED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FINISHED     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_START_FAILED = 3'd5;

  // function codes of an input transaction
  localparam logic FUNC_OBSTACLE = 1'b0;
  localparam logic FUNC_STEP     = 1'b1;

endpackage

### src/grid_coverage_walk_step.sv
`timescale 1ns / 1ps

// Coverage walker over a GRID_COLS x GRID_ROWS occupancy grid. After reset the
// block sweeps the occupancy memory clear, one cell per cycle, over all
// 2**(clog2(GRID_COLS)+clog2(GRID_ROWS)) cells (4096 at 64 x 64), and holds
// in_ready low until that is done. Each transaction then yields exactly one
// result; in_ready stays low from acceptance until the result is taken. An
// obstacle transaction is answered in the cycle after it is accepted. A step
// probes up to four neighbors in order down, forward, up, backward through the
// single read port of the occupancy memory, reading only a neighbor on the grid,
// then backtracks through the visit stack, or finishes when nothing is left to
// backtrack. The first step scans column 0 from the highest row downward.
module grid_coverage_walk_step #(
  parameter int GRID_COLS = gcw_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = gcw_pkg::GRID_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          func,
  input  logic [gcw_pkg::POS_W-1:0]     cell_x,
  input  logic [gcw_pkg::POS_W-1:0]     cell_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gcw_pkg::POS_W-1:0]     pos_x,
  output logic [gcw_pkg::POS_W-1:0]     pos_y,
  output logic [gcw_pkg::KIND_W-1:0]    move_kind,
  output logic                          sweep_dir
);

  import gcw_pkg::*;

  localparam int XW    = $clog2(GRID_COLS);
  localparam int YW    = $clog2(GRID_ROWS);
  localparam int MAW   = XW + YW;
  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int SAW   = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);

  localparam logic [1:0] DIR_DOWN = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_UP   = 2'd2;
  localparam logic [1:0] DIR_BACK = 2'd3;

  typedef enum logic [7:0] {
    ST_CLEAR     = 8'b0000_0001,
    ST_IDLE      = 8'b0000_0010,
    ST_SCAN      = 8'b0000_0100,
    ST_SCAN_TEST = 8'b0000_1000,
    ST_PROBE     = 8'b0001_0000,
    ST_TEST      = 8'b0010_0000,
    ST_POP       = 8'b0100_0000,
    ST_POP_LOAD  = 8'b1000_0000
  } state_t;

  state_t            state;
  logic [MAW-1:0]    clr_addr;
  logic [1:0]        dir;
  logic [YW-1:0]     scan_row;
  logic [XW-1:0]     nbr_x;
  logic [YW-1:0]     nbr_y;
  logic [XW-1:0]     walker_x;
  logic [YW-1:0]     walker_y;
  logic              sweep_rev;
  logic              not_started;
  logic [CNTW-1:0]   stack_count;
  logic [KIND_W-1:0] kind;

  // occupancy memory, addressed {row, column}
  logic [1:0]     cell_map [0:(2**MAW)-1];
  logic [1:0]     map_rd;
  logic           map_we;
  logic [MAW-1:0] map_wa;
  logic [1:0]     map_wd;
  logic [MAW-1:0] map_ra;

  // visit stack holds {row, column}
  logic [MAW-1:0]  visit_stack [0:CELLS-1];
  logic [MAW-1:0]  stk_rd;
  logic            stk_we;
  logic [CNTW-1:0] stk_ra;

  logic            in_xact;
  logic            obs_in_range;
  logic [XW-1:0]   obs_x;
  logic [YW-1:0]   obs_y;
  logic            east;
  logic            nbr_ok;
  logic [XW-1:0]   nbr_x_c;
  logic [YW-1:0]   nbr_y_c;
  logic            found_free;
  logic            can_push;

  assign in_ready  = (state == ST_IDLE) && !out_valid;
  assign in_xact   = in_valid && in_ready;
  assign pos_x     = POS_W'(walker_x);
  assign pos_y     = POS_W'(walker_y);
  assign sweep_dir = sweep_rev;
  assign move_kind = kind;

  assign obs_in_range = (COORD_CMP_W'(cell_x) < COORD_CMP_W'(GRID_COLS)) &&
                        (COORD_CMP_W'(cell_y) < COORD_CMP_W'(GRID_ROWS));
  assign obs_x        = XW'(cell_x);
  assign obs_y        = YW'(cell_y);
  assign found_free   = (map_rd == CELL_FREE);
  assign can_push     = stack_count < CNTW'(CELLS);
  assign stk_ra       = stack_count - CNTW'(2);

  // neighbor for the current probe direction; forward mirrors when sweeping back
  always_comb begin
    east    = ((dir == DIR_FWD) && !sweep_rev) || ((dir == DIR_BACK) && sweep_rev);
    nbr_x_c = walker_x;
    nbr_y_c = walker_y;
    nbr_ok  = 1'b0;
    case (dir)
      DIR_DOWN: begin
        nbr_y_c = walker_y + YW'(1);
        nbr_ok  = walker_y != YW'(GRID_ROWS - 1);
      end
      DIR_UP: begin
        nbr_y_c = walker_y - YW'(1);
        nbr_ok  = walker_y != '0;
      end
      default: begin
        if (east) begin
          nbr_x_c = walker_x + XW'(1);
          nbr_ok  = walker_x != XW'(GRID_COLS - 1);
        end else begin
          nbr_x_c = walker_x - XW'(1);
          nbr_ok  = walker_x != '0;
        end
      end
    endcase
  end

  always_comb begin
    map_we = 1'b0;
    map_wa = {nbr_y, nbr_x};
    map_wd = CELL_VISITED;
    map_ra = {nbr_y_c, nbr_x_c};
    stk_we = 1'b0;
    case (state)
      ST_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr_addr;
        map_wd = CELL_FREE;
      end
      ST_IDLE: begin
        map_we = in_xact && (func == FUNC_OBSTACLE) && obs_in_range;
        map_wa = {obs_y, obs_x};
        map_wd = CELL_BLOCKED;
      end
      ST_SCAN: begin
        map_ra = {scan_row, {XW{1'b0}}};
      end
      ST_SCAN_TEST: begin
        map_we = found_free;
        map_wa = {scan_row, {XW{1'b0}}};
        stk_we = found_free && can_push;
      end
      ST_TEST: begin
        map_we = found_free;
        stk_we = found_free && can_push;
      end
      ST_POP_LOAD: begin
        map_we = 1'b1;
        map_wa = stk_rd;
        map_wd = CELL_REVISITED;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      cell_map[map_wa] <= map_wd;
    end
    map_rd <= cell_map[map_ra];
  end

  // push address is the current count, the entry written is the new walker cell
  always_ff @(posedge clk) begin
    if (stk_we) begin
      visit_stack[stack_count[SAW-1:0]] <= (state == ST_SCAN_TEST) ?
                                           {scan_row, {XW{1'b0}}} : {nbr_y, nbr_x};
    end
    stk_rd <= visit_stack[stk_ra[SAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      dir         <= DIR_DOWN;
      scan_row    <= '0;
      walker_x    <= '0;
      walker_y    <= '0;
      sweep_rev   <= 1'b0;
      not_started <= 1'b1;
      stack_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + MAW'(1);
          if (clr_addr == {MAW{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xact) begin
            if (func == FUNC_OBSTACLE) begin
              kind      <= KIND_OBSTACLE;
              out_valid <= 1'b1;
            end else if (not_started) begin
              scan_row <= YW'(GRID_ROWS - 1);
              state    <= ST_SCAN;
            end else begin
              dir   <= DIR_DOWN;
              state <= ST_PROBE;
            end
          end
        end
        ST_SCAN: begin
          state <= ST_SCAN_TEST;
        end
        ST_SCAN_TEST: begin
          if (found_free) begin
            walker_x    <= '0;
            walker_y    <= scan_row;
            not_started <= 1'b0;
            if (can_push) begin
              stack_count <= stack_count + CNTW'(1);
            end
            kind      <= KIND_STARTED;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else if (scan_row == '0) begin
            kind      <= KIND_START_FAILED;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            scan_row <= scan_row - YW'(1);
            state    <= ST_SCAN;
          end
        end
        ST_PROBE: begin
          nbr_x <= nbr_x_c;
          nbr_y <= nbr_y_c;
          if (nbr_ok) begin
            state <= ST_TEST;
          end else if (dir == DIR_BACK) begin
            state <= ST_POP;
          end else begin
            dir <= dir + 2'd1;
          end
        end
        ST_TEST: begin
          if (found_free) begin
            walker_x <= nbr_x;
            walker_y <= nbr_y;
            if (can_push) begin
              stack_count <= stack_count + CNTW'(1);
            end
            // moving up on the far edge column turns the sweep
            if (dir == DIR_UP) begin
              if (!sweep_rev && (nbr_x == XW'(GRID_COLS - 1))) begin
                sweep_rev <= 1'b1;
              end else if (sweep_rev && (nbr_x == '0)) begin
                sweep_rev <= 1'b0;
              end
            end
            kind      <= KIND_ADVANCED;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end else if (dir == DIR_BACK) begin
            state <= ST_POP;
          end else begin
            dir   <= dir + 2'd1;
            state <= ST_PROBE;
          end
        end
        ST_POP: begin
          if (stack_count <= CNTW'(1)) begin
            stack_count <= '0;
            kind        <= KIND_FINISHED;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end else begin
            // read of the new top entry was issued this cycle
            stack_count <= stack_count - CNTW'(1);
            state       <= ST_POP_LOAD;
          end
        end
        ST_POP_LOAD: begin
          walker_x  <= stk_rd[XW-1:0];
          walker_y  <= stk_rd[MAW-1:XW];
          kind      <= KIND_BACKTRACKED;
          out_valid <= 1'b1;
          state     <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### src/gcw_checker.sv
`timescale 1ns / 1ps

module gcw_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          func,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gcw_pkg::POS_W-1:0]     pos_x,
  input logic [gcw_pkg::POS_W-1:0]     pos_y,
  input logic [gcw_pkg::KIND_W-1:0]    move_kind,
  input logic                          sweep_dir
);

  import gcw_pkg::*;

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(move_kind) && $stable(pos_x) &&
                                $stable(pos_y) && $stable(sweep_dir))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  // obstacle transaction answers in the next cycle
  a_obstacle_kind: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == FUNC_OBSTACLE) |=>
      out_valid && (move_kind == KIND_OBSTACLE))
    else $error("obstacle transaction not answered");

  // obstacles never move the walker or the sweep
  a_obstacle_still: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (func == FUNC_OBSTACLE) |=>
      $stable(pos_x) && $stable(pos_y) && $stable(sweep_dir))
    else $error("obstacle transaction moved the walker");

endmodule

bind grid_coverage_walk_step gcw_checker u_gcw_checker (.*);
